// ===== hw/rtl/mmrf_pkg.sv =====
// Shared types, constants and classification helpers for the MIDI router/filter.
`default_nettype none
package mmrf_pkg;

  localparam int MAX_PORTS = 8;
  localparam int PORT_W    = 3;
  localparam int TYPE_W    = 56;
  localparam int CHAN_W    = 128;
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 6;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  // Register indexes on the configuration port (8-byte stride)
  localparam logic [2:0] REG_IN_TYPE_DROP     = 3'd0;
  localparam logic [2:0] REG_IN_DEST_DROP     = 3'd1;
  localparam logic [2:0] REG_IN_CHAN_DROP_LO  = 3'd2;
  localparam logic [2:0] REG_IN_CHAN_DROP_HI  = 3'd3;
  localparam logic [2:0] REG_OUT_TYPE_DROP    = 3'd4;
  localparam logic [2:0] REG_OUT_CHAN_DROP_LO = 3'd5;
  localparam logic [2:0] REG_OUT_CHAN_DROP_HI = 3'd6;

  typedef enum logic [3:0] {
    CLS_NOTE      = 4'd0,
    CLS_AFTER     = 4'd1,
    CLS_CC        = 4'd2,
    CLS_PROG      = 4'd3,
    CLS_SYSEX     = 4'd4,
    CLS_SONG      = 4'd5,
    CLS_TRANSPORT = 4'd6,
    CLS_DROP      = 4'd7,
    CLS_PASS      = 4'd8
  } cls_t;

  typedef struct packed {
    logic [2:0] source_port;
    logic [7:0] status;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [4:0] midi_channel;
  } in_item_t;

  typedef struct packed {
    logic [2:0] dest_port;
    logic [7:0] out_status;
    logic [6:0] out_first_data;
    logic [6:0] out_second_data;
    logic [4:0] out_channel;
    logic       last_copy;
  } out_item_t;

  typedef struct packed {
    in_item_t               msg;
    logic [MAX_PORTS-1:0]   dest_mask;
  } q_entry_t;

  typedef struct packed {
    logic [TYPE_W-1:0] in_type_drop;
    logic [63:0]       in_dest_drop;
    logic [CHAN_W-1:0] in_chan_drop;
    logic [TYPE_W-1:0] out_type_drop;
    logic [CHAN_W-1:0] out_chan_drop;
  } cfg_t;

  // Sort a status byte into its type class
  function automatic cls_t classify(input logic [7:0] st, input logic out_side);
    cls_t c;
    c = CLS_PASS;
    if (st < 8'h80) begin
      c = CLS_PASS;
    end else if (st < 8'hF0) begin
      case (st[7:4])
        4'h8, 4'h9, 4'hE: c = CLS_NOTE;
        4'hA:             c = CLS_AFTER;
        4'hD:             c = out_side ? CLS_PASS : CLS_AFTER;
        4'hB:             c = CLS_CC;
        4'hC:             c = CLS_PROG;
        default:          c = CLS_PASS;
      endcase
    end else begin
      case (st) inside
        8'hF0:          c = CLS_SYSEX;
        [8'hF1:8'hF6]:  c = CLS_SONG;
        8'hF8, 8'hF9:   c = CLS_DROP;
        [8'hFA:8'hFC]:  c = CLS_TRANSPORT;
        default:        c = CLS_PASS;
      endcase
    end
    return c;
  endfunction

  // Per-port type drop flag lookup
  function automatic logic type_drop(input logic [TYPE_W-1:0] r, input logic [2:0] p,
                                     input cls_t c);
    logic       d;
    logic [5:0] idx;
    idx = ({3'b000, p} * 6'd7) + {3'b000, c[2:0]};
    if (c == CLS_DROP) begin
      d = 1'b1;
    end else if (c == CLS_PASS) begin
      d = 1'b0;
    end else begin
      d = r[idx];
    end
    return d;
  endfunction

  // Per-port channel mask lookup; system and out-of-range channels never match
  function automatic logic chan_drop(input logic [CHAN_W-1:0] r, input logic [2:0] p,
                                     input logic [4:0] ch);
    logic       d;
    logic [3:0] c4;
    logic [6:0] idx;
    c4  = 4'(ch - 5'd1);
    idx = {p, c4};
    if (ch == 5'd0 || ch > 5'd16) begin
      d = 1'b0;
    end else begin
      d = r[idx];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mmrf_front.sv =====
// Front end: classifies an accepted item and builds its destination mask.
`default_nettype none
module mmrf_front
  import mmrf_pkg::*;
#(
  parameter int NUM_PORTS = 8
) (
  input  wire logic     accept,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output logic          push,
  output q_entry_t      entry
);

  cls_t                 cls_in;
  cls_t                 cls_out;
  logic                 src_ok;
  logic                 src_drop;
  logic [MAX_PORTS-1:0] mask;

  // Classify for the source and destination checks
  always_comb begin
    cls_in   = classify(item.status, 1'b0);
    cls_out  = classify(item.status, 1'b1);
    src_ok   = {1'b0, item.source_port} < 4'(NUM_PORTS);
    src_drop = type_drop(cfg.in_type_drop, item.source_port, cls_in) |
               chan_drop(cfg.in_chan_drop, item.source_port, item.midi_channel);
  end

  // Evaluate each destination lane independently
  always_comb begin
    for (int d = 0; d < MAX_PORTS; d++) begin
      mask[d] = (d < NUM_PORTS) &&
                !cfg.in_dest_drop[{item.source_port, 3'(d)}] &&
                !type_drop(cfg.out_type_drop, 3'(d), cls_out) &&
                !chan_drop(cfg.out_chan_drop, 3'(d), item.midi_channel);
    end
  end

  // Queue only items that produce at least one copy
  assign push            = accept && src_ok && !src_drop && (|mask);
  assign entry.msg       = item;
  assign entry.dest_mask = mask;

endmodule
`default_nettype wire

// ===== hw/rtl/mmrf_queue.sv =====
// Short FIFO of classified items between front and back ends.
`default_nettype none
module mmrf_queue
  import mmrf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wr_entry,
  input  wire logic     pop,
  output q_entry_t      rd_entry,
  output logic          empty,
  output logic          full
);

  q_entry_t        q_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]    count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign rd_entry = q_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push ? 1'b1 : 1'b0);
    rd_ptr_nxt = rd_ptr_r + (pop ? 1'b1 : 1'b0);
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mmrf_back.sv =====
// Back end: emits one copy per cycle for each destination in the mask.
`default_nettype none
module mmrf_back
  import mmrf_pkg::*;
#(
  parameter int REMAP_PORT    = 2,
  parameter int REMAP_CHANNEL = 3
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_entry_t head,
  input  wire logic     empty,
  output logic          pop,
  output logic          out_valid,
  output out_item_t     out_item
);

  logic                 cur_valid_r, cur_valid_nxt;
  in_item_t             cur_msg_r, cur_msg_nxt;
  logic [MAX_PORTS-1:0] rem_r, rem_nxt;
  logic [MAX_PORTS-1:0] low_bit;
  logic [PORT_W-1:0]    sel;
  logic                 last;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  // Pick the lowest remaining destination
  always_comb begin
    sel = '0;
    for (int i = MAX_PORTS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        sel = PORT_W'(i);
      end
    end
    low_bit = rem_r & (~rem_r + 1'b1);
    last    = ((rem_r & ~low_bit) == '0);
  end

  // Load the next item as soon as the current one finishes
  assign pop = !empty && (!cur_valid_r || last);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_msg_nxt   = cur_msg_r;
    rem_nxt       = rem_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_msg_nxt   = head.msg;
      rem_nxt       = head.dest_mask;
    end else if (cur_valid_r) begin
      cur_valid_nxt = !last;
      rem_nxt       = rem_r & ~low_bit;
    end
  end

  // Build the outgoing copy
  always_comb begin
    out_valid_nxt                = cur_valid_r;
    out_item_nxt.dest_port       = sel;
    out_item_nxt.out_status      = cur_msg_r.status;
    out_item_nxt.out_first_data  = cur_msg_r.first_data;
    out_item_nxt.out_second_data = cur_msg_r.second_data;
    out_item_nxt.out_channel     = (sel == PORT_W'(REMAP_PORT)) ? 5'(REMAP_CHANNEL)
                                                                 : cur_msg_r.midi_channel;
    out_item_nxt.last_copy       = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_msg_r  <= cur_msg_nxt;
    rem_r      <= rem_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/midi_message_router_filter.sv =====
// Accepted items pass the queue, the current-item register and the output register.
// One copy per cycle; the copies of one item leave back to back, one per destination.
// busy rises while the four-entry item queue is full; items with no copies are not queued.
// Reset (rst_n low, synchronous) empties the queue and clears all filter registers.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
`default_nettype none
module midi_message_router_filter
  import mmrf_pkg::*;
#(
  parameter int NUM_PORTS     = 8,
  parameter int REMAP_PORT    = 2,
  parameter int REMAP_CHANNEL = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  logic [TYPE_W-1:0] in_type_drop_r;
  logic [63:0]       in_dest_drop_r;
  logic [63:0]       in_chan_drop_lo_r;
  logic [63:0]       in_chan_drop_hi_r;
  logic [TYPE_W-1:0] out_type_drop_r;
  logic [63:0]       out_chan_drop_lo_r;
  logic [63:0]       out_chan_drop_hi_r;
  logic [2:0]        reg_idx;
  logic              cfg_wr;
  cfg_t              cfg;
  logic              accept;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;
  q_entry_t          wr_entry;
  q_entry_t          head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write filter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_type_drop_r     <= '0;
      in_dest_drop_r     <= '0;
      in_chan_drop_lo_r  <= '0;
      in_chan_drop_hi_r  <= '0;
      out_type_drop_r    <= '0;
      out_chan_drop_lo_r <= '0;
      out_chan_drop_hi_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IN_TYPE_DROP:     in_type_drop_r     <= pwdata[TYPE_W-1:0];
        REG_IN_DEST_DROP:     in_dest_drop_r     <= pwdata;
        REG_IN_CHAN_DROP_LO:  in_chan_drop_lo_r  <= pwdata;
        REG_IN_CHAN_DROP_HI:  in_chan_drop_hi_r  <= pwdata;
        REG_OUT_TYPE_DROP:    out_type_drop_r    <= pwdata[TYPE_W-1:0];
        REG_OUT_CHAN_DROP_LO: out_chan_drop_lo_r <= pwdata;
        REG_OUT_CHAN_DROP_HI: out_chan_drop_hi_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_IN_TYPE_DROP:     prdata = {8'h00, in_type_drop_r};
      REG_IN_DEST_DROP:     prdata = in_dest_drop_r;
      REG_IN_CHAN_DROP_LO:  prdata = in_chan_drop_lo_r;
      REG_IN_CHAN_DROP_HI:  prdata = in_chan_drop_hi_r;
      REG_OUT_TYPE_DROP:    prdata = {8'h00, out_type_drop_r};
      REG_OUT_CHAN_DROP_LO: prdata = out_chan_drop_lo_r;
      REG_OUT_CHAN_DROP_HI: prdata = out_chan_drop_hi_r;
      default:              prdata = '0;
    endcase
  end

  assign cfg.in_type_drop  = in_type_drop_r;
  assign cfg.in_dest_drop  = in_dest_drop_r;
  assign cfg.in_chan_drop  = {in_chan_drop_hi_r, in_chan_drop_lo_r};
  assign cfg.out_type_drop = out_type_drop_r;
  assign cfg.out_chan_drop = {out_chan_drop_hi_r, out_chan_drop_lo_r};

  // Accept while the queue has room
  assign busy   = q_full;
  assign accept = start && !busy;

  mmrf_front #(
    .NUM_PORTS (NUM_PORTS)
  ) u_front (
    .accept (accept),
    .item   (in_item),
    .cfg    (cfg),
    .push   (push),
    .entry  (wr_entry)
  );

  mmrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  mmrf_back #(
    .REMAP_PORT    (REMAP_PORT),
    .REMAP_CHANNEL (REMAP_CHANNEL)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // Copies of one item leave in consecutive cycles
  a_copies_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_copy |=> out_valid)
    else $error("copy stream broken before last copy");

  // Destinations of one item rise strictly
  a_dest_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_copy |=> out_item.dest_port > $past(out_item.dest_port))
    else $error("destinations not ascending");

  // Only configured ports are addressed
  a_dest_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_item.dest_port} < 4'(NUM_PORTS)))
    else $error("destination beyond port count");

  // Remapped port carries the forced channel
  a_remap_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.dest_port == 3'(REMAP_PORT)) |->
      (out_item.out_channel == 5'(REMAP_CHANNEL)))
    else $error("remapped channel missing");
`endif

endmodule
`default_nettype wire
